// File: rtl/core/jbed_pkg.sv
// Package for the baseline JPEG block entropy decoder and dequantizer.
// Holds item types, command/phase/state enums and the zigzag order.
// No dependencies.
package jbed_pkg;

  // Input commands
  typedef enum logic [2:0] {
    CMD_LOAD_QUANT  = 3'd0,
    CMD_LOAD_COUNT  = 3'd1,
    CMD_LOAD_SYMBOL = 3'd2,
    CMD_SCAN_BIT    = 3'd3,
    CMD_CLEAR       = 3'd4
  } cmd_e;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_BAD_CODE     = 2'd1,
    ERR_RUN_OVERFLOW = 2'd2
  } err_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DC_SELECT    = 2'd0,
    CFG_AC_SELECT    = 2'd1,
    CFG_QUANT_SELECT = 2'd2
  } cfg_e;

  // Decode phase within a block
  typedef enum logic [1:0] {
    PH_DC_SYM   = 2'd0,
    PH_DC_EXTRA = 2'd1,
    PH_AC_SYM   = 2'd2,
    PH_AC_EXTRA = 2'd3
  } phase_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_COUNT  = 2'd1,
    ST_SYMBOL = 2'd2,
    ST_EMIT   = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        table_class;
    logic [1:0]  table_index;
    logic [7:0]  position;
    logic [15:0] load_value;
    logic        scan_bit;
    logic [1:0]  component;
  } jbed_in_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic [5:0]         natural_index;
    logic               last;
    logic [1:0]         error_code;
  } jbed_out_t;

  // Coefficient buffer write
  typedef struct packed {
    logic               en;
    logic [5:0]         addr;
    logic signed [15:0] data;
  } jbed_cw_t;

  // Emit sweep read request
  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic       last;
  } jbed_rd_t;

  localparam int unsigned BLOCK_SIZE  = 64;
  localparam int unsigned MAX_CODELEN = 16;
  localparam logic [7:0]  RUN_MASK    = 8'hF0;
  localparam logic [7:0]  SIZE_MASK   = 8'h0F;

  // Zigzag position to natural (row-major) index
  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // Sign-extend a JPEG magnitude category value of the given size
  function automatic logic signed [15:0] extend(input logic [15:0] v, input logic [3:0] size);
    logic signed [16:0] mask;
    logic signed [16:0] r;
    mask = (17'sd1 <<< size) - 17'sd1;
    if (size == 4'd0) begin
      r = '0;
    end else if (v[size - 4'd1]) begin
      r = $signed({1'b0, v});
    end else begin
      r = $signed({1'b0, v}) - mask;
    end
    return r[15:0];
  endfunction

endpackage

// File: rtl/core/jpeg_block_entropy_dequant_unit.sv
// Top level of the baseline JPEG block entropy decoder and dequantizer.
// Depends on jbed_pkg and jbed_dequant.
//
// Usage: an item is taken when start_i is high and busy_o is low. Loads
// (quantization entries, Huffman counts and symbols), clear and extra bits
// are handled in the idle state. A scan bit during a Huffman symbol goes
// through a count table read and, when a code completes, a symbol table
// read. Both table memories have registered reads.
// When a block completes, the coefficient buffer is swept once, one entry
// per cycle: 64 results follow in natural order, each passing the buffer
// read and output registers; busy_o stays high during the sweep. An invalid
// code or run overflow gives one result with last set and drops the block.
// Results appear on result_o for one cycle with strobe_o; the receiver
// cannot stall them. Configuration writes via cfg_we_i take effect at once;
// the user makes them while the block is idle, as the block does not enforce it.
// Reset clears predictors, decode state and selects; the table memories
// are undefined until loaded.
module jpeg_block_entropy_dequant_unit import jbed_pkg::*; #(
  parameter int HUFF_TABLES       = 4,
  parameter int QUANT_TABLES      = 4,
  parameter int SYMBOLS_PER_TABLE = 256,
  parameter int COMPONENTS        = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  jbed_in_t  in_i,
  output logic      strobe_o,
  output jbed_out_t result_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i
);

  localparam int CDEPTH = 2 * HUFF_TABLES * 16;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int SDEPTH = 2 * HUFF_TABLES * SYMBOLS_PER_TABLE;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int PW     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // Huffman tables
  logic [7:0] cnt_mem [CDEPTH];
  logic [7:0] sym_mem [SDEPTH];
  logic [7:0] cnt_rd_q;
  logic [7:0] sym_rd_q;

  // Control and decode state
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [5:0]  dc_sel_q, ac_sel_q, q_sel_q;
  logic [15:0] acc_q, acc_d;
  logic [4:0]  len_q, len_d;
  logic [16:0] first_q, first_d;
  logic [8:0]  base_q, base_d;
  logic [15:0] xbits_q, xbits_d;
  logic [3:0]  xneed_q, xneed_d;
  logic [3:0]  xsize_q, xsize_d;
  logic [6:0]  zp_q, zp_d;
  logic [3:0]  run_q, run_d;
  logic [1:0]  comp_q, comp_d;
  logic [1:0]  tab_q, tab_d;
  logic        have_q, have_d;
  logic [1:0]  qt_q, qt_d;
  logic [5:0]  k_q, k_d;
  logic signed [15:0] pred_q [COMPONENTS];
  logic signed [15:0] pred_d [COMPONENTS];
  jbed_out_t   out_q, out_d;
  logic        strobe_q, strobe_d;

  // Decisions from the datapath block
  logic        accept;
  logic        go_count, go_symbol, go_emit, fail;
  logic [1:0]  fail_code;
  logic        cnt_re, sym_re;
  logic [CAW-1:0] cnt_ra;
  logic [SAW-1:0] sym_ra;
  jbed_cw_t    cw;
  jbed_rd_t    rd;
  logic        clr;

  logic               prod_vld;
  logic signed [31:0] prod;
  logic [5:0]         prod_idx;
  logic               prod_last;

  assign accept = start_i && !busy_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_sel_q <= '0;
      ac_sel_q <= '0;
      q_sel_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DC_SELECT:    dc_sel_q <= cfg_data_i;
        CFG_AC_SELECT:    ac_sel_q <= cfg_data_i;
        CFG_QUANT_SELECT: q_sel_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Huffman count memory
  always_ff @(posedge clk_i) begin
    if (accept && in_i.cmd == CMD_LOAD_COUNT && 32'(in_i.table_index) < HUFF_TABLES
        && in_i.position < 8'(MAX_CODELEN)) begin
      cnt_mem[CAW'((32'(in_i.table_class) * HUFF_TABLES + 32'(in_i.table_index)) * 16
                   + 32'(in_i.position))] <= in_i.load_value[7:0];
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  // Huffman symbol memory
  always_ff @(posedge clk_i) begin
    if (accept && in_i.cmd == CMD_LOAD_SYMBOL && 32'(in_i.table_index) < HUFF_TABLES
        && 32'(in_i.position) < SYMBOLS_PER_TABLE) begin
      sym_mem[SAW'((32'(in_i.table_class) * HUFF_TABLES + 32'(in_i.table_index))
                   * SYMBOLS_PER_TABLE + 32'(in_i.position))] <= in_i.load_value[7:0];
    end
    if (sym_re) begin
      sym_rd_q <= sym_mem[sym_ra];
    end
  end

  // Datapath: next values of the decode state
  always_comb begin
    logic [1:0]         tsel;
    logic [15:0]        xb;
    logic signed [15:0] ext;
    logic signed [16:0] psum;
    logic signed [15:0] psat;
    logic [6:0]         pos;
    logic [7:0]         cnt;
    logic [17:0]        diff;
    logic               match;
    logic [9:0]         off;
    logic [9:0]         bsum;
    logic [18:0]        fsum;
    logic [7:0]         sym;
    logic               restart_code, restart_block;
    logic               cls;

    phase_d   = phase_q;
    acc_d     = acc_q;
    len_d     = len_q;
    first_d   = first_q;
    base_d    = base_q;
    xbits_d   = xbits_q;
    xneed_d   = xneed_q;
    xsize_d   = xsize_q;
    zp_d      = zp_q;
    run_d     = run_q;
    comp_d    = comp_q;
    tab_d     = tab_q;
    have_d    = have_q;
    qt_d      = qt_q;
    k_d       = k_q;
    pred_d    = pred_q;
    go_count  = 1'b0;
    go_symbol = 1'b0;
    go_emit   = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    cnt_re    = 1'b0;
    sym_re    = 1'b0;
    cnt_ra    = '0;
    sym_ra    = '0;
    cw        = '0;
    rd        = '0;
    clr       = 1'b0;
    restart_code  = 1'b0;
    restart_block = 1'b0;
    tsel  = '0;
    xb    = '0;
    ext   = '0;
    psum  = '0;
    psat  = '0;
    pos   = '0;
    cnt   = '0;
    diff  = '0;
    match = 1'b0;
    off   = '0;
    bsum  = '0;
    fsum  = '0;
    sym   = sym_rd_q;
    cls   = (phase_q == PH_AC_SYM);

    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.cmd == CMD_SCAN_BIT && 32'(in_i.component) < COMPONENTS) begin
          comp_d = in_i.component;
          if (phase_q == PH_DC_EXTRA || phase_q == PH_AC_EXTRA) begin
            // One extra bit; the last one completes the value
            xb      = {xbits_q[14:0], in_i.scan_bit};
            xbits_d = xb;
            xneed_d = xneed_q - 4'd1;
            if (xneed_q == 4'd1) begin
              ext = extend(xb, xsize_q);
              if (phase_q == PH_DC_EXTRA) begin
                psum = 17'(pred_q[PW'(in_i.component)]) + 17'(ext);
                if (psum > 17'sd32767) begin
                  psat = 16'sd32767;
                end else if (psum < -17'sd32768) begin
                  psat = -16'sd32768;
                end else begin
                  psat = psum[15:0];
                end
                pred_d[PW'(in_i.component)] = psat;
                cw      = '{en: 1'b1, addr: 6'd0, data: psat};
                zp_d    = 7'd1;
                phase_d = PH_AC_SYM;
              end else begin
                pos     = zp_q + 7'(run_q);
                cw      = '{en: 1'b1, addr: ZIGZAG[pos[5:0]], data: ext};
                zp_d    = pos + 7'd1;
                run_d   = '0;
                phase_d = PH_AC_SYM;
                if (pos == 7'(BLOCK_SIZE - 1)) begin
                  go_emit = 1'b1;
                end
              end
            end
          end else begin
            // Next code bit; look up the count for this length
            tsel     = cls ? ac_sel_q[{in_i.component, 1'b0} +: 2]
                           : dc_sel_q[{in_i.component, 1'b0} +: 2];
            acc_d    = {acc_q[14:0], in_i.scan_bit};
            len_d    = len_q + 5'd1;
            tab_d    = tsel;
            have_d   = 32'(tsel) < HUFF_TABLES;
            cnt_re   = 32'(tsel) < HUFF_TABLES;
            cnt_ra   = CAW'((32'(cls) * HUFF_TABLES + 32'(tsel)) * 16 + 32'(len_q[3:0]));
            go_count = 1'b1;
          end
        end else if (accept && in_i.cmd == CMD_CLEAR) begin
          for (int c = 0; c < COMPONENTS; c++) begin
            pred_d[c] = '0;
          end
          xsize_d       = '0;
          restart_block = 1'b1;
          clr           = 1'b1;
        end
      end

      ST_COUNT: begin
        cnt   = have_q ? cnt_rd_q : '0;
        diff  = {2'b0, acc_q} - {1'b0, first_q};
        match = ({1'b0, acc_q} >= first_q) && (diff < 18'(cnt));
        if (match) begin
          off          = 10'(base_q) + 10'(diff[7:0]);
          restart_code = 1'b1;
          if (32'(off) >= SYMBOLS_PER_TABLE) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_CODE;
          end else begin
            sym_re    = 1'b1;
            sym_ra    = SAW'((32'(cls) * HUFF_TABLES + 32'(tab_q)) * SYMBOLS_PER_TABLE
                             + 32'(off));
            go_symbol = 1'b1;
          end
        end else begin
          bsum    = 10'(base_q) + 10'(cnt);
          base_d  = (32'(bsum) > SYMBOLS_PER_TABLE) ? 9'(SYMBOLS_PER_TABLE) : bsum[8:0];
          fsum    = (19'(first_q) + 19'(cnt)) << 1;
          first_d = (fsum > 19'h1FFFF) ? 17'h1FFFF : fsum[16:0];
          if (len_q >= 5'(MAX_CODELEN)) begin
            restart_code = 1'b1;
            fail         = 1'b1;
            fail_code    = ERR_BAD_CODE;
          end
        end
      end

      ST_SYMBOL: begin
        if (phase_q == PH_DC_SYM) begin
          if (sym > 8'd15) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_CODE;
          end else if (sym == 8'd0) begin
            // Zero difference: predictor unchanged
            cw      = '{en: 1'b1, addr: 6'd0, data: pred_q[PW'(comp_q)]};
            zp_d    = 7'd1;
            phase_d = PH_AC_SYM;
          end else begin
            xneed_d = sym[3:0];
            xsize_d = sym[3:0];
            xbits_d = '0;
            phase_d = PH_DC_EXTRA;
          end
        end else begin
          pos = zp_q + 7'(sym[7:4]);
          if (sym == 8'd0) begin
            // End of block
            go_emit = 1'b1;
          end else if ((sym & SIZE_MASK) == 8'd0) begin
            // Run of zeros with no value
            if (pos > 7'(BLOCK_SIZE - 1)) begin
              fail      = 1'b1;
              fail_code = ERR_RUN_OVERFLOW;
            end else begin
              cw   = '{en: 1'b1, addr: ZIGZAG[pos[5:0]], data: '0};
              zp_d = pos + 7'd1;
              if (pos == 7'(BLOCK_SIZE - 1)) begin
                go_emit = 1'b1;
              end
            end
          end else if (pos > 7'(BLOCK_SIZE - 1)) begin
            fail      = 1'b1;
            fail_code = ERR_RUN_OVERFLOW;
          end else begin
            run_d   = 4'((sym & RUN_MASK) >> 4);
            xneed_d = sym[3:0];
            xsize_d = sym[3:0];
            xbits_d = '0;
            phase_d = PH_AC_EXTRA;
          end
        end
      end

      ST_EMIT: begin
        rd  = '{en: 1'b1, idx: k_q, last: (k_q == 6'(BLOCK_SIZE - 1))};
        k_d = k_q + 6'd1;
        if (k_q == 6'(BLOCK_SIZE - 1)) begin
          clr = 1'b1;
        end
      end

      default: ;
    endcase

    // Block finished: sweep out, then start over at a DC symbol
    if (go_emit) begin
      qt_d          = q_sel_q[{comp_d, 1'b0} +: 2];
      k_d           = '0;
      restart_block = 1'b1;
    end
    if (fail) begin
      restart_block = 1'b1;
      clr           = 1'b1;
    end
    if (restart_block) begin
      restart_code = 1'b1;
      phase_d      = PH_DC_SYM;
      xbits_d      = '0;
      xneed_d      = '0;
      zp_d         = '0;
      run_d        = '0;
    end
    if (restart_code) begin
      acc_d   = '0;
      len_d   = '0;
      first_d = '0;
      base_d  = '0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_emit) begin
          state_d = ST_EMIT;
        end else if (go_count) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        state_d = go_symbol ? ST_SYMBOL : ST_IDLE;
      end
      ST_SYMBOL: begin
        state_d = go_emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (k_q == 6'(BLOCK_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: error result or dequantized coefficient
  always_comb begin
    out_d    = out_q;
    strobe_d = 1'b0;
    if (fail) begin
      out_d    = '{coefficient: '0, natural_index: '0, last: 1'b1, error_code: fail_code};
      strobe_d = 1'b1;
    end else if (prod_vld) begin
      out_d    = '{coefficient: prod, natural_index: prod_idx, last: prod_last,
                   error_code: ERR_NONE};
      strobe_d = 1'b1;
    end
  end

  assign busy_o   = (state_q != ST_IDLE) || prod_vld;
  assign strobe_o = strobe_q;
  assign result_o = out_q;

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_DC_SYM;
      acc_q    <= '0;
      len_q    <= '0;
      first_q  <= '0;
      base_q   <= '0;
      xbits_q  <= '0;
      xneed_q  <= '0;
      xsize_q  <= '0;
      zp_q     <= '0;
      run_q    <= '0;
      comp_q   <= '0;
      tab_q    <= '0;
      have_q   <= 1'b0;
      qt_q     <= '0;
      k_q      <= '0;
      strobe_q <= 1'b0;
      for (int c = 0; c < COMPONENTS; c++) begin
        pred_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      first_q  <= first_d;
      base_q   <= base_d;
      xbits_q  <= xbits_d;
      xneed_q  <= xneed_d;
      xsize_q  <= xsize_d;
      zp_q     <= zp_d;
      run_q    <= run_d;
      comp_q   <= comp_d;
      tab_q    <= tab_d;
      have_q   <= have_d;
      qt_q     <= qt_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
      pred_q   <= pred_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  jbed_dequant #(
    .QUANT_TABLES(QUANT_TABLES)
  ) u_dequant (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_we_i     (accept && in_i.cmd == CMD_LOAD_QUANT && in_i.position < 8'(BLOCK_SIZE)),
    .q_tab_i    (in_i.table_index),
    .q_idx_i    (ZIGZAG[in_i.position[5:0]]),
    .q_data_i   (in_i.load_value),
    .cw_i       (cw),
    .clr_i      (clr),
    .rd_i       (rd),
    .qt_i       (qt_q),
    .prod_vld_o (prod_vld),
    .prod_o     (prod),
    .prod_idx_o (prod_idx),
    .prod_last_o(prod_last)
  );

`ifndef SYNTH
  // An error result always closes the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && result_o.error_code != ERR_NONE |-> result_o.last)
    else $error("error result without last");

  // The sweep ends after the last coefficient is read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && k_q == 6'(BLOCK_SIZE - 1) |=> state_q == ST_IDLE && prod_vld)
    else $error("emit sweep did not end cleanly");

  // The buffer is never written while it is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !cw.en && !fail)
    else $error("buffer write during emit");

  // The last coefficient of a block carries the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && result_o.error_code == ERR_NONE
      |-> result_o.last == (result_o.natural_index == 6'(BLOCK_SIZE - 1)))
    else $error("last flag misplaced");
`endif

endmodule

// File: rtl/core/jbed_dequant.sv
// Coefficient buffer, quantization store and dequantizing multiplier.
// Depends on jbed_pkg.
module jbed_dequant import jbed_pkg::*; #(
  parameter int QUANT_TABLES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_we_i,
  input  logic [1:0]         q_tab_i,
  input  logic [5:0]         q_idx_i,
  input  logic [15:0]        q_data_i,
  input  jbed_cw_t           cw_i,
  input  logic               clr_i,
  input  jbed_rd_t           rd_i,
  input  logic [1:0]         qt_i,
  output logic               prod_vld_o,
  output logic signed [31:0] prod_o,
  output logic [5:0]         prod_idx_o,
  output logic               prod_last_o
);

  localparam int QDEPTH = QUANT_TABLES * 64;
  localparam int QAW    = $clog2(QDEPTH);

  logic signed [15:0] coef_mem [64];
  logic [15:0]        quant_mem [QDEPTH];
  logic [63:0]        valid_q;

  logic signed [15:0] cdat_q;
  logic               cval_q;
  logic [15:0]        qdat_q;
  logic               qhave_q;
  logic               vld_q;
  logic [5:0]         idx_q;
  logic               last_q;

  logic               rd_have;
  logic signed [16:0] coef_ext;
  logic signed [16:0] q_ext;
  logic signed [33:0] prod_full;

  assign rd_have = 32'(qt_i) < QUANT_TABLES;

  // Quantization store, written in natural order
  always_ff @(posedge clk_i) begin
    if (q_we_i && (32'(q_tab_i) < QUANT_TABLES)) begin
      quant_mem[QAW'(32'(q_tab_i) * 64 + 32'(q_idx_i))] <= q_data_i;
    end
    if (rd_i.en && rd_have) begin
      qdat_q <= quant_mem[QAW'(32'(qt_i) * 64 + 32'(rd_i.idx))];
    end
  end

  // Coefficient buffer data
  always_ff @(posedge clk_i) begin
    if (cw_i.en) begin
      coef_mem[cw_i.addr] <= cw_i.data;
    end
    if (rd_i.en) begin
      cdat_q <= coef_mem[rd_i.idx];
      cval_q <= valid_q[rd_i.idx];
      idx_q  <= rd_i.idx;
      last_q <= rd_i.last;
      qhave_q <= rd_have;
    end
  end

  // Written marks: an unmarked entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (cw_i.en) begin
        valid_q[cw_i.addr] <= 1'b1;
      end
      vld_q <= rd_i.en;
    end
  end

  // Dequantize
  assign coef_ext  = cval_q ? 17'(cdat_q) : '0;
  assign q_ext     = qhave_q ? $signed({1'b0, qdat_q}) : '0;
  assign prod_full = 34'(coef_ext * q_ext);

  assign prod_vld_o  = vld_q;
  assign prod_o      = prod_full[31:0];
  assign prod_idx_o  = idx_q;
  assign prod_last_o = last_q;

endmodule
